// ===== src/tfd_pkg.sv =====
// Shared types, codes and header layout tables for the trace frame deframer.
// Depends on nothing; every module of the block and the testbench import it.
package tfd_pkg;

  // Frame header size in bytes.
  localparam int unsigned HDR_BYTES = 64;

  // Configuration register indexes (byte address is 4 * index).
  localparam logic [1:0] REG_MAGIC     = 2'd0;
  localparam logic [1:0] REG_VERSION   = 2'd1;
  localparam logic [1:0] REG_MASK_KIND = 2'd2;

  // Result record codes.
  localparam logic [1:0] REC_HEADER  = 2'd0;
  localparam logic [1:0] REC_TRACE   = 2'd1;
  localparam logic [1:0] REC_VERDICT = 2'd2;

  // Trace field indexes.
  localparam logic [3:0] TF_DETECTOR = 4'd0;
  localparam logic [3:0] TF_KIND     = 4'd1;
  localparam logic [3:0] TF_AVG      = 4'd2;
  localparam logic [3:0] TF_FILLED   = 4'd3;
  localparam logic [3:0] TF_OFFSET   = 4'd4;
  localparam logic [3:0] TF_BYTES    = 4'd5;

  // Header fields whose values the parser keeps.
  localparam logic [3:0] HF_TRACE_COUNT = 4'd3;
  localparam logic [3:0] HF_BIN_COUNT   = 4'd9;
  localparam logic [3:0] HF_FRAME_LEN   = 4'd11;

  // Frame verdict codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_MAGIC     = 3'd2,
    ST_VERSION   = 3'd3,
    ST_LENGTH    = 3'd4,
    ST_TRACE_HDR = 3'd5,
    ST_PAYLOAD   = 3'd6,
    ST_TRAILING  = 3'd7
  } status_t;

  // Configuration register values.
  typedef struct packed {
    logic [7:0] magic;
    logic [7:0] version;
    logic [7:0] mask_kind;
  } cfg_t;

  // One queue entry: all results that a single byte causes, in delivery order
  // field, payload offset, payload size, verdict.
  typedef struct packed {
    logic        fld_v;
    logic        fld_trace;
    logic [3:0]  fld_idx;
    logic [63:0] fld_value;
    logic [7:0]  trace_num;
    logic        ext_v;
    logic [31:0] offset;
    logic [34:0] nbytes;
    logic        vrd_v;
    status_t     status;
  } entry_t;

  // Where a header byte falls inside the field layout.
  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
    logic       first;
    logic       last;
    logic [2:0] lane;
  } hdr_slot_t;

  localparam logic [6:0] FLD_START [16] = '{
    7'd2, 7'd3, 7'd4, 7'd6, 7'd8, 7'd12, 7'd16, 7'd24,
    7'd32, 7'd40, 7'd44, 7'd48, 7'd52, 7'd56, 7'd60, 7'd62
  };
  localparam logic [6:0] FLD_SIZE [16] = '{
    7'd1, 7'd1, 7'd2, 7'd1, 7'd4, 7'd4, 7'd8, 7'd8,
    7'd8, 7'd4, 7'd4, 7'd4, 7'd4, 7'd4, 7'd2, 7'd2
  };

  // Decodes a header byte position into field, first/last flag and byte lane.
  function automatic hdr_slot_t hdr_lookup(input logic [5:0] pos);
    hdr_slot_t  s;
    logic [6:0] off;
    s   = '0;
    off = '0;
    for (int i = 0; i < 16; i++) begin
      if (!s.hit && ({1'b0, pos} >= FLD_START[i]) &&
          ({1'b0, pos} < FLD_START[i] + FLD_SIZE[i])) begin
        off     = {1'b0, pos} - FLD_START[i];
        s.hit   = 1'b1;
        s.idx   = 4'(i);
        s.first = (off == 7'd0);
        s.last  = (off == FLD_SIZE[i] - 7'd1);
        s.lane  = off[2:0];
      end
    end
    return s;
  endfunction

endpackage

// ===== src/tfd_if.sv =====
// Handshake channel interfaces for the trace frame deframer: byte input
// channel and result channel. No dependencies.
interface tfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       end_of_frame;

  modport source(output valid, frame_byte, end_of_frame, input ready);
  modport sink(input valid, frame_byte, end_of_frame, output ready);
endinterface

interface tfd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record;
  logic [3:0]  field_index;
  logic [63:0] field_value;
  logic [7:0]  trace_number;
  logic [2:0]  status;
  logic        last_result;

  modport source(output valid, record, field_index, field_value, trace_number,
                 status, last_result, input ready);
  modport sink(input valid, record, field_index, field_value, trace_number,
               status, last_result, output ready);
endinterface

// ===== src/tfd_cfg.sv =====
// APB-style configuration registers of the trace frame deframer.
// Depends on tfd_pkg for the register indexes and the cfg_t type.
module tfd_cfg
  import tfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register write decode.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_MAGIC:     cfg_nxt.magic     = pwdata[7:0];
        REG_VERSION:   cfg_nxt.version   = pwdata[7:0];
        REG_MASK_KIND: cfg_nxt.mask_kind = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (paddr[3:2])
      REG_MAGIC:     prdata = {24'd0, cfg_r.magic};
      REG_VERSION:   prdata = {24'd0, cfg_r.version};
      REG_MASK_KIND: prdata = {24'd0, cfg_r.mask_kind};
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== src/tfd_front.sv =====
// Front end of the trace frame deframer: parses each accepted byte and
// builds the queue entry of the results it causes. Depends on tfd_pkg.
module tfd_front
  import tfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       fire,
  input  logic [7:0] frame_byte,
  input  logic       end_of_frame,
  output logic       push,
  output entry_t     entry
);

  typedef enum logic [6:0] {
    PH_HEADER   = 7'b0000001,
    PH_THDR     = 7'b0000010,
    PH_PAYLOAD  = 7'b0000100,
    PH_DONE     = 7'b0001000,
    PH_BADMAGIC = 7'b0010000,
    PH_BADVER   = 7'b0100000,
    PH_TRAILING = 7'b1000000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] length_r, length_nxt;
  logic [7:0]  traces_r, traces_nxt;
  logic [31:0] bins_r, bins_nxt;
  logic [7:0]  done_cnt_r, done_cnt_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [34:0] left_r, left_nxt;
  logic [2:0]  tbyte_r, tbyte_nxt;

  hdr_slot_t   slot;
  logic [34:0] pay_bytes;
  logic [34:0] left_dec;
  logic [7:0]  done_inc;
  logic [63:0] byte_ext;
  logic        in_header;

  assign byte_ext  = {56'd0, frame_byte};
  assign in_header = (pos_r[31:6] == 26'd0);
  assign slot      = hdr_lookup(pos_r[5:0]);
  assign left_dec  = left_r - 35'd1;
  assign done_inc  = done_cnt_r + 8'd1;

  // Payload size: mask kind rounds the bin count up to a multiple of four, others take four per bin.
  always_comb begin
    if (kind_r == cfg.mask_kind) begin
      pay_bytes = ({3'd0, bins_r} + 35'd3) & ~35'd3;
    end else begin
      pay_bytes = {1'b0, bins_r, 2'b00};
    end
  end

  // Byte parser.
  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    acc_nxt      = acc_r;
    length_nxt   = length_r;
    traces_nxt   = traces_r;
    bins_nxt     = bins_r;
    done_cnt_nxt = done_cnt_r;
    kind_nxt     = kind_r;
    left_nxt     = left_r;
    tbyte_nxt    = tbyte_r;
    entry        = '0;
    entry.status = ST_OK;

    if (fire) begin
      if (pos_r != 32'hFFFF_FFFF) begin
        pos_nxt = pos_r + 32'd1;
      end

      if (in_header) begin
        // Identity checks on the first two bytes.
        if (pos_r[5:0] == 6'd0 && frame_byte != cfg.magic) begin
          phase_nxt = PH_BADMAGIC;
        end
        if (pos_r[5:0] == 6'd1 && phase_r == PH_HEADER && frame_byte != cfg.version) begin
          phase_nxt = PH_BADVER;
        end
        // Little-endian field assembly.
        if (slot.hit) begin
          if (slot.first) begin
            acc_nxt = byte_ext;
          end else begin
            acc_nxt = acc_r | (byte_ext << {slot.lane, 3'b000});
          end
          if (slot.last) begin
            if (slot.idx == HF_TRACE_COUNT) traces_nxt = acc_nxt[7:0];
            if (slot.idx == HF_BIN_COUNT)   bins_nxt   = acc_nxt[31:0];
            if (slot.idx == HF_FRAME_LEN)   length_nxt = acc_nxt[31:0];
            if (phase_nxt == PH_HEADER) begin
              entry.fld_v     = 1'b1;
              entry.fld_idx   = slot.idx;
              entry.fld_value = acc_nxt;
            end
          end
        end
        if (pos_r[5:0] == 6'd63 && phase_nxt == PH_HEADER) begin
          phase_nxt = (traces_nxt == 8'd0) ? PH_DONE : PH_THDR;
        end
      end else begin
        unique case (phase_r)
          PH_THDR: begin
            entry.fld_trace = 1'b1;
            entry.trace_num = done_cnt_r;
            tbyte_nxt       = tbyte_r + 3'd1;
            case (tbyte_r)
              3'd0: begin
                entry.fld_v     = 1'b1;
                entry.fld_idx   = TF_DETECTOR;
                entry.fld_value = byte_ext;
              end
              3'd1: begin
                kind_nxt        = frame_byte;
                entry.fld_v     = 1'b1;
                entry.fld_idx   = TF_KIND;
                entry.fld_value = byte_ext;
              end
              3'd2, 3'd4: acc_nxt = byte_ext;
              3'd3: begin
                acc_nxt         = acc_r | (byte_ext << 8);
                entry.fld_v     = 1'b1;
                entry.fld_idx   = TF_AVG;
                entry.fld_value = acc_nxt;
              end
              3'd5: acc_nxt = acc_r | (byte_ext << 8);
              3'd6: acc_nxt = acc_r | (byte_ext << 16);
              default: begin
                // Last trace header byte: filled count, payload offset and size.
                acc_nxt         = acc_r | (byte_ext << 24);
                entry.fld_v     = 1'b1;
                entry.fld_idx   = TF_FILLED;
                entry.fld_value = acc_nxt;
                entry.ext_v     = 1'b1;
                entry.offset    = pos_nxt;
                entry.nbytes    = pay_bytes;
                if (pay_bytes == 35'd0) begin
                  done_cnt_nxt = done_inc;
                  phase_nxt    = (done_inc == traces_r) ? PH_DONE : PH_THDR;
                end else begin
                  left_nxt  = pay_bytes;
                  phase_nxt = PH_PAYLOAD;
                end
              end
            endcase
          end
          PH_PAYLOAD: begin
            left_nxt = left_dec;
            if (left_dec == 35'd0) begin
              done_cnt_nxt = done_inc;
              phase_nxt    = (done_inc == traces_r) ? PH_DONE : PH_THDR;
            end
          end
          PH_DONE: phase_nxt = PH_TRAILING;
          default: ;
        endcase
      end

      // Frame verdict, first failed check wins.
      if (end_of_frame) begin
        entry.vrd_v = 1'b1;
        if (pos_r < 32'(HDR_BYTES - 1)) begin
          entry.status = ST_SHORT;
        end else if (phase_nxt == PH_BADMAGIC) begin
          entry.status = ST_MAGIC;
        end else if (phase_nxt == PH_BADVER) begin
          entry.status = ST_VERSION;
        end else if (pos_nxt == 32'hFFFF_FFFF || length_nxt != pos_nxt) begin
          entry.status = ST_LENGTH;
        end else if (phase_nxt == PH_THDR) begin
          entry.status = ST_TRACE_HDR;
        end else if (phase_nxt == PH_PAYLOAD) begin
          entry.status = ST_PAYLOAD;
        end else if (phase_nxt == PH_TRAILING) begin
          entry.status = ST_TRAILING;
        end else begin
          entry.status = ST_OK;
        end
        // The frame is over: the parser starts afresh.
        phase_nxt    = PH_HEADER;
        pos_nxt      = '0;
        acc_nxt      = '0;
        length_nxt   = '0;
        traces_nxt   = '0;
        bins_nxt     = '0;
        done_cnt_nxt = '0;
        kind_nxt     = '0;
        left_nxt     = '0;
        tbyte_nxt    = '0;
      end
    end
  end

  assign push = fire && (entry.fld_v || entry.ext_v || entry.vrd_v);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      pos_r      <= '0;
      acc_r      <= '0;
      length_r   <= '0;
      traces_r   <= '0;
      bins_r     <= '0;
      done_cnt_r <= '0;
      kind_r     <= '0;
      left_r     <= '0;
      tbyte_r    <= '0;
    end else begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      acc_r      <= acc_nxt;
      length_r   <= length_nxt;
      traces_r   <= traces_nxt;
      bins_r     <= bins_nxt;
      done_cnt_r <= done_cnt_nxt;
      kind_r     <= kind_nxt;
      left_r     <= left_nxt;
      tbyte_r    <= tbyte_nxt;
    end
  end

endmodule

// ===== src/tfd_fifo.sv =====
// Short entry queue between the front and back ends of the deframer.
// Depends on tfd_pkg for the entry_t type.
module tfd_fifo
  import tfd_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output entry_t head,
  output logic   not_empty,
  output logic   full
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign head      = mem_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> !full) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("queue read while empty");
`endif

endmodule

// ===== src/tfd_back.sv =====
// Back end of the trace frame deframer: unpacks queue entries into single
// result beats behind an output register. Depends on tfd_pkg and tfd_if.
module tfd_back
  import tfd_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  entry_t         head,
  input  logic           q_valid,
  output logic           pop,
  tfd_result_if.source   out_ch
);

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  record_r, record_nxt;
  logic [3:0]  index_r, index_nxt;
  logic [63:0] value_r, value_nxt;
  logic [7:0]  tnum_r, tnum_nxt;
  logic [2:0]  status_r, status_nxt;
  logic        last_r, last_nxt;
  logic [3:0]  sent_r, sent_nxt;

  logic [3:0]  mask;
  logic [3:0]  pend;
  logic [3:0]  sel;
  logic        load;

  // Results still owed by the head entry, in delivery order.
  assign mask = {head.vrd_v, head.ext_v, head.ext_v, head.fld_v};
  assign pend = mask & ~sent_r;
  assign load = q_valid && (!out_valid_r || out_ch.ready);
  assign pop  = load && ((pend & ~sel) == 4'd0);

  always_comb begin
    if (pend[0]) begin
      sel = 4'b0001;
    end else if (pend[1]) begin
      sel = 4'b0010;
    end else if (pend[2]) begin
      sel = 4'b0100;
    end else begin
      sel = {pend[3], 3'b000};
    end
  end

  // Next result beat.
  always_comb begin
    out_valid_nxt = out_valid_r;
    record_nxt    = record_r;
    index_nxt     = index_r;
    value_nxt     = value_r;
    tnum_nxt      = tnum_r;
    status_nxt    = status_r;
    last_nxt      = last_r;
    sent_nxt      = sent_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      status_nxt    = ST_OK;
      last_nxt      = 1'b0;
      tnum_nxt      = head.trace_num;
      record_nxt    = REC_TRACE;
      if (sel[0]) begin
        record_nxt = head.fld_trace ? REC_TRACE : REC_HEADER;
        index_nxt  = head.fld_idx;
        value_nxt  = head.fld_value;
        tnum_nxt   = head.fld_trace ? head.trace_num : 8'd0;
      end else if (sel[1]) begin
        index_nxt = TF_OFFSET;
        value_nxt = {32'd0, head.offset};
      end else if (sel[2]) begin
        index_nxt = TF_BYTES;
        value_nxt = {29'd0, head.nbytes};
      end else begin
        record_nxt = REC_VERDICT;
        index_nxt  = 4'd0;
        value_nxt  = 64'd0;
        tnum_nxt   = 8'd0;
        status_nxt = head.status;
        last_nxt   = 1'b1;
      end
      sent_nxt = pop ? 4'd0 : (sent_r | sel);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sent_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sent_r      <= sent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    record_r <= record_nxt;
    index_r  <= index_nxt;
    value_r  <= value_nxt;
    tnum_r   <= tnum_nxt;
    status_r <= status_nxt;
    last_r   <= last_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.record       = record_r;
  assign out_ch.field_index  = index_r;
  assign out_ch.field_value  = value_r;
  assign out_ch.trace_number = tnum_r;
  assign out_ch.status       = status_r;
  assign out_ch.last_result  = last_r;

`ifndef SYNTHESIS
  a_sent_subset: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> ((sent_r & ~mask) == 4'd0)) else $error("sent mask outside entry");
  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((record_r == REC_VERDICT) == last_r))
    else $error("verdict and last flag disagree");
  a_pop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> sent_r == 4'd0) else $error("sent mask kept after pop");
`endif

endmodule

// ===== src/trace_frame_deframer.sv =====
// Trace frame deframer: one byte per beat in, header and trace fields plus a verdict out.
// The results of a byte pass through the entry queue and then the output register to the port.
// Throughput: one byte per cycle while the queue has room; a byte yields up to four results,
// drained one per cycle through the QUEUE_DEPTH-entry queue, so the result port sets the pace.
// Reset: synchronous active-low rst_n clears parser, queue and output valid; the
// configuration registers reset to zero. No clearing pass is needed.
module trace_frame_deframer
  import tfd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  tfd_byte_if.sink     in_ch,
  tfd_result_if.source out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  cfg_t   cfg;
  entry_t push_entry;
  entry_t head;
  logic   push;
  logic   pop;
  logic   q_valid;
  logic   q_full;
  logic   fire;

  // Input beats are taken whenever the queue has room.
  assign in_ch.ready = !q_full;
  assign fire        = in_ch.valid && !q_full;

  tfd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tfd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .fire         (fire),
    .frame_byte   (in_ch.frame_byte),
    .end_of_frame (in_ch.end_of_frame),
    .push         (push),
    .entry        (push_entry)
  );

  tfd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_entry),
    .pop       (pop),
    .head      (head),
    .not_empty (q_valid),
    .full      (q_full)
  );

  tfd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_valid (q_valid),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== sim/tb_trace_frame_deframer.sv =====
// Self-checking testbench for trace_frame_deframer: builds byte frames, predicts every
// header field, trace field and verdict, and checks the result channel beat by beat.
// Depends on tfd_pkg (src/tfd_pkg.sv), the channel interfaces (src/tfd_if.sv) and the RTL.
module tb_trace_frame_deframer;
  import tfd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HEADER_LEN   = 64;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned RANDOM_BYTES = 60;

  // Header layout: first byte and width of each of the 16 named fields.
  localparam int unsigned FIELD_AT [16] = '{
    2, 3, 4, 6, 8, 12, 16, 24, 32, 40, 44, 48, 52, 56, 60, 62
  };
  localparam int unsigned FIELD_LEN [16] = '{
    1, 1, 2, 1, 4, 4, 8, 8, 8, 4, 4, 4, 4, 4, 2, 2
  };

  typedef enum logic [2:0] {
    PARSE_HEADER,
    PARSE_TRACE_HDR,
    PARSE_PAYLOAD,
    PARSE_DONE,
    PARSE_BAD_MAGIC,
    PARSE_BAD_VERSION,
    PARSE_TRAILING
  } parse_phase_e;

  // Ways in which a generated frame departs from a well-formed one.
  typedef enum int {
    FLAW_NONE,
    FLAW_SHORT,
    FLAW_MAGIC,
    FLAW_VERSION,
    FLAW_LENGTH,
    FLAW_CUT_THDR,
    FLAW_CUT_PAYLOAD,
    FLAW_TRAILING,
    FLAW_NOISE
  } flaw_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  typedef struct packed {
    logic [1:0]  rec;
    logic [3:0]  idx;
    logic [63:0] value;
    logic [7:0]  trace_num;
    status_t     status;
    logic        last;
  } field_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tfd_byte_if   byte_if ();
  tfd_result_if result_if ();

  trace_frame_deframer i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (byte_if),
    .out_ch  (result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Register values as the block should hold them.
  logic [7:0] cfg_magic = 8'd0;
  logic [7:0] cfg_version = 8'd0;
  logic [7:0] cfg_mask_kind = 8'd0;

  // Parser state of the prediction.
  logic [31:0]  pos_count;
  logic [63:0]  accum;
  parse_phase_e phase;
  logic         hdr_ok;
  logic [31:0]  decl_length;
  logic [7:0]   decl_traces;
  logic [31:0]  decl_bins;
  logic [7:0]   traces_done;
  logic [7:0]   kind_held;
  logic [34:0]  payload_left;
  logic [2:0]   thdr_byte;

  frame_beat_t   byte_queue [$];
  field_result_t expected_fields [$];

  int unsigned beats_total = 0;
  int unsigned bytes_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned frames_sent = 0;
  int unsigned settings_used = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned verdict_seen [8] = '{default: 0};

  // Sender and receiver pacing.
  frame_beat_t beat;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned rx_cycle = 0;
  int unsigned rx_mode = 0;
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 30;

  // Clock.
  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Parser state after reset and after every verdict.
  function automatic void clear_parser();
    pos_count    = '0;
    accum        = '0;
    phase        = PARSE_HEADER;
    hdr_ok       = 1'b1;
    decl_length  = '0;
    decl_traces  = '0;
    decl_bins    = '0;
    traces_done  = '0;
    kind_held    = '0;
    payload_left = '0;
    thdr_byte    = '0;
  endfunction

  function automatic void expect_result(input logic [1:0] rec, input logic [3:0] idx,
                                        input logic [63:0] value, input logic [7:0] tn,
                                        input status_t status, input logic last);
    field_result_t r;
    r.rec       = rec;
    r.idx       = idx;
    r.value     = value;
    r.trace_num = tn;
    r.status    = status;
    r.last      = last;
    expected_fields.insert(expected_fields.size(), r);
  endfunction

  function automatic void trace_complete();
    traces_done = traces_done + 8'd1;
    phase = (traces_done == decl_traces) ? PARSE_DONE : PARSE_TRACE_HDR;
  endfunction

  // Works out the results that one accepted byte causes.
  function automatic void predict_byte(input logic [7:0] b, input logic eof);
    logic [31:0] p;
    logic        hit;
    logic [63:0] nbytes;
    status_t     verdict;
    p   = pos_count;
    hit = 1'b0;
    if (pos_count != 32'hFFFF_FFFF) pos_count = pos_count + 32'd1;

    if (p < HEADER_LEN) begin
      if (p == 0 && b != cfg_magic) begin
        hdr_ok = 1'b0;
        phase  = PARSE_BAD_MAGIC;
      end
      if (p == 1 && phase == PARSE_HEADER && b != cfg_version) begin
        hdr_ok = 1'b0;
        phase  = PARSE_BAD_VERSION;
      end
      // Assemble the little-endian header field this byte belongs to.
      for (int i = 0; i < 16; i++) begin
        if (!hit && p >= FIELD_AT[i] && p < FIELD_AT[i] + FIELD_LEN[i]) begin
          hit = 1'b1;
          if (p == FIELD_AT[i]) accum = {56'd0, b};
          else accum = accum | ({56'd0, b} << ((p - FIELD_AT[i]) * 8));
          if (p == FIELD_AT[i] + FIELD_LEN[i] - 1) begin
            if (i == HF_TRACE_COUNT) decl_traces = accum[7:0];
            if (i == HF_BIN_COUNT) decl_bins = accum[31:0];
            if (i == HF_FRAME_LEN) decl_length = accum[31:0];
            if (hdr_ok) expect_result(REC_HEADER, 4'(i), accum, 8'd0, ST_OK, 1'b0);
          end
        end
      end
      if (p == HEADER_LEN - 1 && hdr_ok)
        phase = (decl_traces == 8'd0) ? PARSE_DONE : PARSE_TRACE_HDR;
    end else if (phase == PARSE_TRACE_HDR) begin
      // Eight-byte trace header: detector, kind, 16-bit average, 32-bit filled bins.
      case (thdr_byte)
        3'd0: begin
          expect_result(REC_TRACE, TF_DETECTOR, {56'd0, b}, traces_done, ST_OK, 1'b0);
        end
        3'd1: begin
          kind_held = b;
          expect_result(REC_TRACE, TF_KIND, {56'd0, b}, traces_done, ST_OK, 1'b0);
        end
        3'd2, 3'd4: begin
          accum = {56'd0, b};
        end
        3'd3: begin
          accum = accum | ({56'd0, b} << 8);
          expect_result(REC_TRACE, TF_AVG, accum, traces_done, ST_OK, 1'b0);
        end
        3'd5: begin
          accum = accum | ({56'd0, b} << 8);
        end
        3'd6: begin
          accum = accum | ({56'd0, b} << 16);
        end
        default: begin
          accum = accum | ({56'd0, b} << 24);
          expect_result(REC_TRACE, TF_FILLED, accum, traces_done, ST_OK, 1'b0);
          // Mask payloads are the bin count padded to a word, others four bytes a bin.
          if (kind_held == cfg_mask_kind) nbytes = ({32'd0, decl_bins} + 64'd3) & ~64'd3;
          else nbytes = {32'd0, decl_bins} * 64'd4;
          expect_result(REC_TRACE, TF_OFFSET, {32'd0, pos_count}, traces_done, ST_OK, 1'b0);
          expect_result(REC_TRACE, TF_BYTES, nbytes, traces_done, ST_OK, 1'b0);
          if (nbytes == 64'd0) begin
            trace_complete();
          end else begin
            payload_left = nbytes[34:0];
            phase = PARSE_PAYLOAD;
          end
        end
      endcase
      thdr_byte = thdr_byte + 3'd1;
    end else if (phase == PARSE_PAYLOAD) begin
      payload_left = payload_left - 35'd1;
      if (payload_left == 35'd0) trace_complete();
    end else if (phase == PARSE_DONE) begin
      phase = PARSE_TRAILING;
    end

    // Verdict, with the checks in their order of precedence.
    if (eof) begin
      if ((p + 32'd1) < HEADER_LEN && pos_count < HEADER_LEN) verdict = ST_SHORT;
      else if (phase == PARSE_BAD_MAGIC) verdict = ST_MAGIC;
      else if (phase == PARSE_BAD_VERSION) verdict = ST_VERSION;
      else if (pos_count == 32'hFFFF_FFFF || decl_length != pos_count) verdict = ST_LENGTH;
      else if (phase == PARSE_TRACE_HDR) verdict = ST_TRACE_HDR;
      else if (phase == PARSE_PAYLOAD) verdict = ST_PAYLOAD;
      else if (phase == PARSE_TRAILING) verdict = ST_TRAILING;
      else verdict = ST_OK;
      expect_result(REC_VERDICT, 4'd0, 64'd0, 8'd0, verdict, 1'b1);
      clear_parser();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Frame building
  // ---------------------------------------------------------------------------

  task automatic push_beat(input logic [7:0] data, input logic last);
    frame_beat_t fb;
    fb.data = data;
    fb.last = last;
    byte_queue.insert(byte_queue.size(), fb);
    beats_total++;
  endtask

  // Builds one frame with random content and the given shape, then queues its bytes.
  // Payloads of huge declared sizes are only partly built; such frames must be cut.
  task automatic queue_frame(input int unsigned n_traces, input logic [31:0] bin_count,
                             input int unsigned mask_pct, input flaw_e flaw);
    logic [7:0]  frame [$];
    int unsigned thdr_at [$];
    int unsigned pay_at [$];
    int unsigned pay_gen [$];
    logic [7:0]  kind;
    logic [63:0] plen;
    logic [31:0] flen;
    int unsigned gen;
    int unsigned cut;
    int unsigned t;
    for (int i = 0; i < HEADER_LEN; i++) frame.insert(frame.size(), 8'($urandom));
    frame[0] = cfg_magic;
    frame[1] = cfg_version;
    if (flaw == FLAW_MAGIC) frame[0] = cfg_magic ^ 8'($urandom_range(1, 255));
    if (flaw == FLAW_VERSION) frame[1] = cfg_version ^ 8'($urandom_range(1, 255));
    frame[FIELD_AT[HF_TRACE_COUNT]] = 8'(n_traces);
    for (int i = 0; i < 4; i++) frame[FIELD_AT[HF_BIN_COUNT] + i] = bin_count[8*i +: 8];

    // Trace records.
    for (int n = 0; n < n_traces; n++) begin
      kind = ($urandom_range(0, 99) < mask_pct) ? cfg_mask_kind : 8'($urandom);
      thdr_at.insert(thdr_at.size(), frame.size());
      frame.insert(frame.size(), 8'($urandom));
      frame.insert(frame.size(), kind);
      repeat (6) frame.insert(frame.size(), 8'($urandom));
      if (kind == cfg_mask_kind) plen = ({32'd0, bin_count} + 64'd3) & ~64'd3;
      else plen = {32'd0, bin_count} * 64'd4;
      gen = (plen > 64'd64) ? 64 : int'(plen);
      pay_at.insert(pay_at.size(), frame.size());
      pay_gen.insert(pay_gen.size(), gen);
      repeat (gen) frame.insert(frame.size(), 8'($urandom));
    end

    // Where the frame ends.
    case (flaw)
      FLAW_SHORT: begin
        cut = $urandom_range(1, HEADER_LEN - 1);
      end
      FLAW_CUT_THDR: begin
        t   = $urandom_range(0, thdr_at.size() - 1);
        cut = thdr_at[t] + $urandom_range(0, 7);
      end
      FLAW_CUT_PAYLOAD: begin
        t   = $urandom_range(0, pay_at.size() - 1);
        cut = pay_at[t] + $urandom_range(0, pay_gen[t] - 1);
      end
      FLAW_NOISE: begin
        cut = $urandom_range(1, 90);
      end
      default: begin
        cut = frame.size();
      end
    endcase
    while (frame.size() > cut) void'(frame.pop_back());
    if (flaw == FLAW_TRAILING) begin
      repeat ($urandom_range(1, 6)) frame.insert(frame.size(), 8'($urandom));
    end

    // Noise keeps the magic byte only half of the time; otherwise the length field
    // states the real size unless a length error is wanted.
    if (flaw == FLAW_NOISE) begin
      foreach (frame[i]) frame[i] = 8'($urandom);
      if ($urandom_range(0, 1) == 0) frame[0] = cfg_magic;
    end else if (frame.size() >= FIELD_AT[HF_FRAME_LEN] + 4) begin
      flen = 32'(frame.size());
      if (flaw == FLAW_LENGTH) flen = flen ^ (32'd1 << $urandom_range(0, 31));
      for (int i = 0; i < 4; i++) frame[FIELD_AT[HF_FRAME_LEN] + i] = flen[8*i +: 8];
    end

    foreach (frame[i]) push_beat(frame[i], i == frame.size() - 1);
    frames_sent++;
  endtask

  // Mostly well-formed frames, the rest broken in one way or pure noise.
  task automatic random_frame();
    int unsigned roll;
    int unsigned n;
    logic [31:0] bin_count;
    flaw_e       flaw;
    roll      = $urandom_range(0, 99);
    n         = $urandom_range(0, 3);
    bin_count = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
    if (roll < 12) flaw = FLAW_NOISE;
    else if (roll < 65) flaw = FLAW_NONE;
    else flaw = flaw_e'($urandom_range(FLAW_SHORT, FLAW_TRAILING));
    if ((flaw == FLAW_CUT_THDR || flaw == FLAW_CUT_PAYLOAD) && n == 0) n = 1;
    if (flaw == FLAW_CUT_PAYLOAD && bin_count == 0) bin_count = 1;
    queue_frame(n, bin_count, 50, flaw);
  endtask

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------

  // Setup then access cycle; the upper data bits carry junk that the block drops.
  task automatic reg_write(input logic [1:0] idx, input logic [7:0] value);
    logic [31:0] word;
    word       = $urandom;
    word[7:0]  = value;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MAGIC:     cfg_magic = value;
      REG_VERSION:   cfg_version = value;
      REG_MASK_KIND: cfg_mask_kind = value;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [7:0] magic, input logic [7:0] version,
                                input logic [7:0] mask_kind);
    reg_write(REG_MAGIC, magic);
    reg_write(REG_VERSION, version);
    reg_write(REG_MASK_KIND, mask_kind);
    settings_used++;
  endtask

  // Waits until every queued byte has been taken and every result has come back.
  task automatic wait_drained();
    while (bytes_accepted != beats_total || expected_fields.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned phase_start;
    byte_if.valid        = 1'b0;
    byte_if.frame_byte   = 8'd0;
    byte_if.end_of_frame = 1'b0;
    result_if.ready      = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    clear_parser();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames with the registers at their reset values: one-byte frames, a
    // padded mask payload, and the widest payload sizes for both kinds of trace.
    settings_used = 1;
    push_beat(8'hFF, 1'b1);
    push_beat(8'h00, 1'b1);
    queue_frame(1, 32'd5, 100, FLAW_NONE);
    queue_frame(1, 32'hFFFF_FFFF, 100, FLAW_CUT_PAYLOAD);
    queue_frame(1, 32'hFFFF_FFFF, 0, FLAW_CUT_PAYLOAD);
    wait_drained();

    // Random frames under two register settings, all ones first.
    for (int s = 0; s < 2; s++) begin
      case (s)
        0:       apply_settings(8'hFF, 8'hFF, 8'hFF);
        default: apply_settings(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      phase_start = beats_total;
      while (beats_total - phase_start < RANDOM_BYTES) random_frame();
      wait_drained();
    end

    $display("Run covered %0d frames, %0d bytes and %0d results under %0d register settings.",
             frames_sent, bytes_accepted, results_seen, settings_used);
    $display("Verdicts by code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d.",
             verdict_seen[0], verdict_seen[1], verdict_seen[2], verdict_seen[3],
             verdict_seen[4], verdict_seen[5], verdict_seen[6], verdict_seen[7]);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Byte driver: bursts of random length with random gaps; predicts on each beat taken.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      byte_if.valid <= 1'b0;
    end else begin
      if (byte_if.valid && byte_if.ready) begin
        predict_byte(byte_if.frame_byte, byte_if.end_of_frame);
        bytes_accepted++;
      end
      if (!byte_if.valid || byte_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          byte_if.valid <= 1'b0;
        end else if (byte_queue.size() != 0) begin
          beat = byte_queue.pop_front();
          byte_if.frame_byte   <= beat.data;
          byte_if.end_of_frame <= beat.last;
          byte_if.valid        <= 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          byte_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks each beat against the oldest expectation and paces ready.
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    field_result_t want;
    if (!rst_n) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (expected_fields.size() == 0) begin
          $error("unexpected result: record %0d index %0d value 0x%0h status %0d",
                 result_if.record, result_if.field_index, result_if.field_value,
                 result_if.status);
          mismatches++;
        end else begin
          want = expected_fields.pop_front();
          check_field("record", 64'(want.rec), 64'(result_if.record));
          check_field("field_index", 64'(want.idx), 64'(result_if.field_index));
          check_field("field_value", want.value, result_if.field_value);
          check_field("trace_number", 64'(want.trace_num), 64'(result_if.trace_number));
          check_field("status", 64'(want.status), 64'(result_if.status));
          check_field("last_result", 64'(want.last), 64'(result_if.last_result));
          if (want.rec == REC_VERDICT) verdict_seen[want.status]++;
        end
        results_seen++;
        // Now and then hold off for a long stretch so that the block backs up.
        if (results_seen == next_hold_at) begin
          hold_left    = HOLD_CYCLES;
          next_hold_at = next_hold_at + 70;
        end
      end

      rx_cycle++;
      if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left != 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       result_if.ready <= 1'b1;
          1:       result_if.ready <= 1'($urandom_range(0, 1));
          2:       result_if.ready <= ($urandom_range(0, 3) == 0);
          default: result_if.ready <= (rx_cycle % 3 == 0);
        endcase
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $error("timeout after %0d cycles with %0d results outstanding",
             cycles, expected_fields.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
